// ===== sv/v2d_pkg.sv =====
// Shared widths, operation codes, status codes and lane control type for the 2D vector unit.
package v2d_pkg;

  // Word format: signed fixed point with FRAC_BITS fraction bits.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int FUNC_BITS = 4;
  localparam int TOL_BITS  = WORD_BITS - 1;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(66);

  // Root width covers the square root of two squared full-scale differences.
  localparam int RB      = WORD_BITS + 1;
  localparam int SQ_BITS = 2 * RB;
  // Dividend width: magnitude shifted by the fraction bits plus half the divisor.
  localparam int NB      = WORD_BITS + FRAC_BITS + 1;

  // Pipeline positions: root leaves the square root at stage KS,
  // the result register is stage LAT.
  localparam int KS  = 3 + RB;
  localparam int LAT = KS + 4 + WORD_BITS;

  // Operation codes.
  localparam logic [FUNC_BITS-1:0] FN_ADD   = 4'd0;
  localparam logic [FUNC_BITS-1:0] FN_SUB   = 4'd1;
  localparam logic [FUNC_BITS-1:0] FN_SCALE = 4'd2;
  localparam logic [FUNC_BITS-1:0] FN_DIV   = 4'd3;
  localparam logic [FUNC_BITS-1:0] FN_NEG   = 4'd4;
  localparam logic [FUNC_BITS-1:0] FN_EQ    = 4'd5;
  localparam logic [FUNC_BITS-1:0] FN_MAG   = 4'd6;
  localparam logic [FUNC_BITS-1:0] FN_DIST  = 4'd7;
  localparam logic [FUNC_BITS-1:0] FN_NORM  = 4'd8;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Control that the top level hands to each component lane.
  typedef struct packed {
    logic                 en;
    logic [FUNC_BITS-1:0] func;
  } lane_ctl_t;

endpackage

// ===== sv/v2d_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module v2d_sqrt import v2d_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SQ_BITS-1:0] rad_i,
  output logic [RB-1:0]      root_o
);

  logic [SQ_BITS-1:0] rem_q   [RB];
  logic [SQ_BITS-1:0] rem_in  [RB];
  logic [SQ_BITS-1:0] rem_d   [RB];
  logic [SQ_BITS-1:0] trial   [RB];
  logic [RB-1:0]      root_q  [RB];
  logic [RB-1:0]      root_in [RB];
  logic [RB-1:0]      root_d  [RB];

  // Each stage takes the previous stage's partial root and remainder.
  always_comb begin
    rem_in[0]  = rad_i;
    root_in[0] = '0;
    for (int j = 1; j < RB; j++) begin
      rem_in[j]  = rem_q[j-1];
      root_in[j] = root_q[j-1];
    end
  end

  // Try the next lower root bit: the square grows by 2*r*2^b + 2^(2b).
  always_comb begin
    for (int j = 0; j < RB; j++) begin
      trial[j] = (SQ_BITS'(root_in[j]) << (RB - j)) + (SQ_BITS'(1) << (2 * (RB - 1 - j)));
      if (rem_in[j] >= trial[j]) begin
        rem_d[j]  = rem_in[j] - trial[j];
        root_d[j] = root_in[j] | (RB'(1) << (RB - 1 - j));
      end else begin
        rem_d[j]  = rem_in[j];
        root_d[j] = root_in[j];
      end
    end
  end

  // Stage registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < RB; j++) begin
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
      end
    end
  end

  assign root_o = root_q[RB-1];

endmodule

// ===== sv/v2d_lane.sv =====
// One component lane: add, subtract, negate, scale, the squared component, and a pipelined divider.
module v2d_lane import v2d_pkg::*; (
  input  logic                        clk_i,
  input  lane_ctl_t                   ctl_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  input  logic signed [WORD_BITS-1:0] s_i,
  input  logic [RB-1:0]               root_i,
  input  logic                        norm_ok_i,
  output logic [SQ_BITS-1:0]          sq_o,
  output logic signed [WORD_BITS-1:0] r_o,
  output logic                        sat_o
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam logic [W-1:0]   SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W:0]   RND  = (2*W+1)'(1) << (F - 1);

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [W-1:0]         val;
    logic                 sat;
    logic [W-1:0]         am;
    logic                 aneg;
    logic [W-1:0]         sm;
    logic                 sneg;
    logic                 sz;
  } pl_t;

  typedef struct packed {
    pl_t          pl;
    logic         use_div;
    logic         dneg;
    logic [RB-1:0] dm;
    logic [NB-1:0] n;
  } dz_t;

  typedef struct packed {
    pl_t           pl;
    logic          use_div;
    logic          dneg;
    logic          ovf;
    logic [RB-1:0] dm;
    logic [RB-1:0] rem;
    logic [W-1:0]  nlo;
    logic [W-1:0]  q;
  } dv_t;

  // Clamp a W+1 bit two's complement value; returns {sat, value}.
  function automatic logic [W:0] clamp1(input logic [W:0] v);
    if (v[W] != v[W-1]) begin
      return {1'b1, (v[W] ? SMIN : SMAX)};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  // Apply a sign to a magnitude with saturation; returns {sat, value}.
  function automatic logic [W:0] fmag(input logic neg, input logic over, input logic [W-1:0] m);
    logic [W-1:0] lim;
    logic         sat;
    logic [W-1:0] mm;
    lim = neg ? SMIN : SMAX;
    sat = over || (m > lim);
    mm  = sat ? lim : m;
    return {sat, (neg ? W'(-mm) : mm)};
  endfunction

  logic [W:0]          a_e, b_e, sum, dif, ng;
  logic [W:0]          e1;
  pl_t                 pl1_d, pl1_q, pl2_q, pl3_d;
  logic signed [W:0]   v1_q;
  logic [2*W-1:0]      prod2_q;
  logic [SQ_BITS-1:0]  sq2_q;
  logic [2*W:0]        pr;
  logic [2*W-F:0]      mg;
  logic [W:0]          sc;
  pl_t                 dl_q [RB+1];
  pl_t                 p;
  dz_t                 d0_d, d0_q;
  logic [RB-1:0]       half;
  dv_t                 dv_q [W+1];
  dv_t                 dv_d [W];
  dv_t                 d1_d;
  logic [RB:0]         t;
  logic [W:0]          fin;

  // First stage: exact add, subtract and negate, divide-by-zero, magnitudes.
  always_comb begin
    a_e = {a_i[W-1], a_i};
    b_e = {b_i[W-1], b_i};
    sum = a_e + b_e;
    dif = a_e - b_e;
    ng  = -a_e;
    case (ctl_i.func)
      FN_ADD: e1 = clamp1(sum);
      FN_SUB: e1 = clamp1(dif);
      FN_NEG: e1 = clamp1(ng);
      FN_DIV: begin
        if (s_i == '0) begin
          e1 = {1'b0, (a_i[W-1] ? SMIN : ((a_i != '0) ? SMAX : {W{1'b0}}))};
        end else begin
          e1 = '0;
        end
      end
      default: e1 = '0;
    endcase
    pl1_d.func = ctl_i.func;
    pl1_d.sat  = e1[W];
    pl1_d.val  = e1[W-1:0];
    pl1_d.am   = a_i[W-1] ? W'(-a_i) : a_i;
    pl1_d.aneg = a_i[W-1];
    pl1_d.sm   = s_i[W-1] ? W'(-s_i) : s_i;
    pl1_d.sneg = s_i[W-1];
    pl1_d.sz   = (s_i == '0);
  end

  // Third stage: round and saturate the scale product.
  always_comb begin
    pr    = {1'b0, prod2_q} + RND;
    mg    = pr[2*W:F];
    sc    = fmag(pl2_q.aneg ^ pl2_q.sneg, |mg[2*W-F:W], mg[W-1:0]);
    pl3_d = pl2_q;
    if (pl2_q.func == FN_SCALE) begin
      pl3_d.sat = sc[W];
      pl3_d.val = sc[W-1:0];
    end
  end

  // Divider setup: pick the divisor and add half of it for rounding.
  always_comb begin
    p            = dl_q[RB];
    d0_d.pl      = p;
    d0_d.use_div = ((p.func == FN_DIV) && !p.sz) || ((p.func == FN_NORM) && norm_ok_i);
    d0_d.dneg    = (p.func == FN_DIV) && p.sneg;
    d0_d.dm      = (p.func == FN_DIV) ? {1'b0, p.sm} : root_i;
    half         = d0_d.dm >> 1;
    d0_d.n       = NB'({p.am, {F{1'b0}}}) + NB'(half);
  end

  // Overflow check against the divisor shifted by a word, then the upper remainder.
  always_comb begin
    d1_d.pl      = d0_q.pl;
    d1_d.use_div = d0_q.use_div;
    d1_d.dneg    = d0_q.dneg;
    d1_d.dm      = d0_q.dm;
    d1_d.ovf     = {{(W-F){1'b0}}, d0_q.n} >= {d0_q.dm, {W{1'b0}}};
    d1_d.rem     = {{(W-F){1'b0}}, d0_q.n[NB-1:W]};
    d1_d.nlo     = d0_q.n[W-1:0];
    d1_d.q       = '0;
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    t = '0;
    for (int j = 0; j < W; j++) begin
      dv_d[j] = dv_q[j];
      t = {dv_q[j].rem, dv_q[j].nlo[W-1-j]};
      if (t >= {1'b0, dv_q[j].dm}) begin
        dv_d[j].rem       = RB'(t - {1'b0, dv_q[j].dm});
        dv_d[j].q[W-1-j]  = 1'b1;
      end else begin
        dv_d[j].rem = t[RB-1:0];
      end
    end
  end

  // Final sign and saturation of the quotient.
  assign fin = fmag(dv_q[W].pl.aneg ^ dv_q[W].dneg, dv_q[W].ovf, dv_q[W].q);

  // Lane registers, all advancing together.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      pl1_q   <= pl1_d;
      v1_q    <= (ctl_i.func == FN_DIST) ? dif : a_e;
      pl2_q   <= pl1_q;
      prod2_q <= pl1_q.am * pl1_q.sm;
      sq2_q   <= v1_q * v1_q;
      dl_q[0] <= pl3_d;
      for (int j = 1; j <= RB; j++) begin
        dl_q[j] <= dl_q[j-1];
      end
      d0_q    <= d0_d;
      dv_q[0] <= d1_d;
      for (int j = 0; j < W; j++) begin
        dv_q[j+1] <= dv_d[j];
      end
      r_o   <= dv_q[W].use_div ? fin[W-1:0] : dv_q[W].pl.val;
      sat_o <= dv_q[W].use_div ? fin[W] : dv_q[W].pl.sat;
    end
  end

  assign sq_o = sq2_q;

endmodule

// ===== sv/vector2d_fixed_point_alu.sv =====
// Top level of the 2D vector unit: input stage, x and y lanes, square root and result merge.
// One request is taken every clock cycle while the result side keeps up; each request passes
// through 3 setup stages, a 33-stage square root, divider setup stages, a 32-stage divider and
// its finish stage, then the result register. Every operation runs the whole pipeline, so
// results leave in request order. A stall on the result side while a result is waiting
// freezes the pipeline and raises in_stall_o in the same cycle.
// The tolerance register (reset 66) may be written only while no request is in flight.
module vector2d_fixed_point_alu import v2d_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tolerance_we_i,
  input  logic [TOL_BITS-1:0]         tolerance_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [FUNC_BITS-1:0]        func_i,
  input  logic signed [WORD_BITS-1:0] a_x_i,
  input  logic signed [WORD_BITS-1:0] a_y_i,
  input  logic signed [WORD_BITS-1:0] b_x_i,
  input  logic signed [WORD_BITS-1:0] b_y_i,
  input  logic signed [WORD_BITS-1:0] scalar_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] r_x_o,
  output logic signed [WORD_BITS-1:0] r_y_o,
  output logic [WORD_BITS-1:0]        length_o,
  output logic                        equal_o,
  output logic [1:0]                  status_o
);

  localparam int W = WORD_BITS;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic                 dz;
    logic                 eq;
    logic [W-1:0]         len;
    logic                 lsat;
  } tp_t;

  logic                 en;
  logic [TOL_BITS-1:0]  tol_q;
  logic [LAT:0]         vld_q;
  logic [FUNC_BITS-1:0] func0_q;
  logic [W-1:0]         ax0_q, ay0_q, bx0_q, by0_q, s0_q;
  logic [W:0]           dx1_q, dy1_q, adx, ady;
  lane_ctl_t            ctl;
  logic [SQ_BITS-1:0]   sqx, sqy, rad_q;
  logic [RB-1:0]        root;
  logic                 norm_ok, lf;
  logic [W-1:0]         rx, ry;
  logic                 satx, saty;
  tp_t                  tp_q [LAT-1];
  tp_t                  tp_d [LAT-1];
  tp_t                  f;
  logic [W-1:0]         r_x_q, r_y_q, len_q;
  logic                 eq_q;
  logic [1:0]           st_q, st_d;

  // The whole pipeline advances unless a finished result is held.
  assign en         = !(vld_q[LAT] && out_stall_i);
  assign in_stall_o = !en;

  // Tolerance register and valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      vld_q <= '0;
    end else begin
      if (tolerance_we_i) begin
        tol_q <= tolerance_i;
      end
      if (en) begin
        vld_q <= {vld_q[LAT-1:0], in_valid_i};
      end
    end
  end

  // Input stage and the sum of squares ahead of the square root.
  always_ff @(posedge clk_i) begin
    if (en) begin
      func0_q <= func_i;
      ax0_q   <= a_x_i;
      ay0_q   <= a_y_i;
      bx0_q   <= b_x_i;
      by0_q   <= b_y_i;
      s0_q    <= scalar_i;
      dx1_q   <= {bx0_q[W-1], bx0_q} - {ax0_q[W-1], ax0_q};
      dy1_q   <= {by0_q[W-1], by0_q} - {ay0_q[W-1], ay0_q};
      rad_q   <= sqx + sqy;
    end
  end

  assign ctl = '{en: en, func: func0_q};

  v2d_lane u_lane_x (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .a_i      (ax0_q),
    .b_i      (bx0_q),
    .s_i      (s0_q),
    .root_i   (root),
    .norm_ok_i(norm_ok),
    .sq_o     (sqx),
    .r_o      (rx),
    .sat_o    (satx)
  );

  v2d_lane u_lane_y (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .a_i      (ay0_q),
    .b_i      (by0_q),
    .s_i      (s0_q),
    .root_i   (root),
    .norm_ok_i(norm_ok),
    .sq_o     (sqy),
    .r_o      (ry),
    .sat_o    (saty)
  );

  v2d_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (rad_q),
    .root_o(root)
  );

  // Normalize divides only when the magnitude is above the tolerance.
  assign norm_ok = root > RB'(tol_q);

  // Per-request side information travelling beside the lanes.
  always_comb begin
    adx = dx1_q[W] ? (W+1)'(-dx1_q) : dx1_q;
    ady = dy1_q[W] ? (W+1)'(-dy1_q) : dy1_q;
    lf  = 1'b0;
    tp_d[0] = '{func: func0_q, dz: (s0_q == '0), eq: 1'b0, len: '0, lsat: 1'b0};
    for (int k = 1; k < LAT - 1; k++) begin
      tp_d[k] = tp_q[k-1];
      if (k == 1) begin
        tp_d[k].eq = (tp_q[k-1].func == FN_EQ) &&
                     (adx < (W+1)'(tol_q)) && (ady < (W+1)'(tol_q));
      end
      if (k == KS) begin
        lf = (tp_q[k-1].func == FN_MAG) || (tp_q[k-1].func == FN_DIST) ||
             (tp_q[k-1].func == FN_NORM);
        tp_d[k].lsat = lf && root[RB-1];
        tp_d[k].len  = lf ? (root[RB-1] ? '1 : root[W-1:0]) : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < LAT - 1; k++) begin
        tp_q[k] <= tp_d[k];
      end
    end
  end

  // Merge the lanes into the result and its status.
  always_comb begin
    f = tp_q[LAT-2];
    if ((f.func == FN_DIV) && f.dz) begin
      st_d = ST_DIV0;
    end else if (satx || saty || f.lsat) begin
      st_d = ST_SAT;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_x_q <= rx;
      r_y_q <= ry;
      len_q <= f.len;
      eq_q  <= f.eq;
      st_q  <= st_d;
    end
  end

  assign out_valid_o = vld_q[LAT];
  assign r_x_o       = r_x_q;
  assign r_y_o       = r_y_q;
  assign length_o    = len_q;
  assign equal_o     = eq_q;
  assign status_o    = st_q;

  // A division by zero never carries a length or an equality flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_DIV0)) |-> ((length_o == '0) && !equal_o))
    else $error("division by zero result carries length or equal");

  // An equality result has a zero vector and a clean status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && equal_o) |-> ((r_x_o == '0) && (r_y_o == '0) && (status_o == ST_OK)))
    else $error("equality result with nonzero vector or status");

  // An accepted request enters the first pipeline stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted request lost at the input stage");

endmodule
